FILE: hdl/dpeq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpeq_pkg: shared types and sizes for the dual priority event queue
// Queue depths, pointer widths, command codes and the stored event record.
// ----------------------------------------------------------------------------
package dpeq_pkg;

  localparam int POST_DEPTH = 16;
  localparam int SYNC_DEPTH = 16;

  localparam int POST_AW = (POST_DEPTH > 1) ? $clog2(POST_DEPTH) : 1;
  localparam int SYNC_AW = (SYNC_DEPTH > 1) ? $clog2(SYNC_DEPTH) : 1;
  localparam int SYNC_CW = $clog2(SYNC_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH_POST = 2'd0,
    OP_PUSH_SYNC = 2'd1,
    OP_POP       = 2'd2
  } op_t;

  typedef struct packed {
    logic [15:0] handler;
    logic [15:0] evt;
    logic [31:0] word;
    logic [31:0] tag;
  } event_t;

endpackage
`default_nettype wire

FILE: hdl/dpeq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpeq_ram: event store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dpeq_ram #(
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire dpeq_pkg::event_t                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output dpeq_pkg::event_t                           rdata
);

  dpeq_pkg::event_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/dual_priority_event_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_priority_event_queue_top: two-FIFO event queue with strict priority
// Posted events go to a ring that keeps one slot free, synchronous events to
// a counted FIFO; a pop serves the synchronous FIFO first.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive op, handler_id, event_id, word_param, tag_param
//   and raise start; the item is taken at a rising edge with start high and
//   busy low. op 0 pushes a posted event, 1 a synchronous event, 2 pops.
//   Result channel: done is high for exactly one cycle, in the cycle after the
//   item was taken, with push_ok, pop_valid, pop_is_sync and the popped
//   event on out_handler, out_event, out_word, out_tag (zero unless
//   pop_valid). Results cannot be held off and must be captured on done.
//   One item is taken every cycle: the pointer update, store write and
//   store read all complete in the accepting cycle, the read data landing
//   in the store's output register.
//   A full queue refuses a push (push_ok low); a pop of two empty queues
//   returns pop_valid low. op 3 does nothing.
//   Reset (rst, synchronous) empties both queues; busy is high for the
//   first cycle after reset and low from then on. Store contents are not
//   cleared.
// ----------------------------------------------------------------------------
module dual_priority_event_queue_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] handler_id,
  input  wire logic [15:0] event_id,
  input  wire logic [31:0] word_param,
  input  wire logic [31:0] tag_param,
  output logic             done,
  output logic             push_ok,
  output logic             pop_valid,
  output logic             pop_is_sync,
  output logic [15:0]      out_handler,
  output logic [15:0]      out_event,
  output logic [31:0]      out_word,
  output logic [31:0]      out_tag
);

  logic [dpeq_pkg::POST_AW-1:0] post_rd;
  logic [dpeq_pkg::POST_AW-1:0] post_wr;
  logic [dpeq_pkg::SYNC_AW-1:0] sync_head;
  logic [dpeq_pkg::SYNC_AW-1:0] sync_tail;
  logic [dpeq_pkg::SYNC_CW-1:0] sync_count;

  logic [dpeq_pkg::POST_AW-1:0] post_wr_inc;
  logic [dpeq_pkg::POST_AW-1:0] post_rd_inc;
  logic [dpeq_pkg::SYNC_AW-1:0] sync_head_inc;
  logic [dpeq_pkg::SYNC_AW-1:0] sync_tail_inc;

  logic             accept;
  logic             post_push;
  logic             sync_push;
  logic             sync_pop;
  logic             post_pop;
  dpeq_pkg::event_t in_evt;
  dpeq_pkg::event_t post_rdata;
  dpeq_pkg::event_t sync_rdata;
  dpeq_pkg::event_t sel_evt;

  assign accept = start && !busy;
  assign in_evt = '{handler: handler_id, evt: event_id, word: word_param, tag: tag_param};

  assign post_wr_inc = (post_wr == dpeq_pkg::POST_AW'(dpeq_pkg::POST_DEPTH - 1)) ?
                       '0 : post_wr + 1'b1;
  assign post_rd_inc = (post_rd == dpeq_pkg::POST_AW'(dpeq_pkg::POST_DEPTH - 1)) ?
                       '0 : post_rd + 1'b1;
  assign sync_tail_inc = (sync_tail == dpeq_pkg::SYNC_AW'(dpeq_pkg::SYNC_DEPTH - 1)) ?
                         '0 : sync_tail + 1'b1;
  assign sync_head_inc = (sync_head == dpeq_pkg::SYNC_AW'(dpeq_pkg::SYNC_DEPTH - 1)) ?
                         '0 : sync_head + 1'b1;

  always_comb begin
    post_push = 1'b0;
    sync_push = 1'b0;
    sync_pop  = 1'b0;
    post_pop  = 1'b0;
    if (accept) begin
      unique case (dpeq_pkg::op_t'(op))
        dpeq_pkg::OP_PUSH_POST: begin
          post_push = (post_wr_inc != post_rd);
        end
        dpeq_pkg::OP_PUSH_SYNC: begin
          sync_push = (sync_count != dpeq_pkg::SYNC_CW'(dpeq_pkg::SYNC_DEPTH));
        end
        dpeq_pkg::OP_POP: begin
          sync_pop = (sync_count != '0);
          post_pop = (sync_count == '0) && (post_rd != post_wr);
        end
        default: begin
        end
      endcase
    end
  end

  dpeq_ram #(.DEPTH(dpeq_pkg::POST_DEPTH)) u_post_ram (
    .clk   (clk),
    .we    (post_push),
    .waddr (post_wr),
    .wdata (in_evt),
    .re    (post_pop),
    .raddr (post_rd),
    .rdata (post_rdata)
  );

  dpeq_ram #(.DEPTH(dpeq_pkg::SYNC_DEPTH)) u_sync_ram (
    .clk   (clk),
    .we    (sync_push),
    .waddr (sync_tail),
    .wdata (in_evt),
    .re    (sync_pop),
    .raddr (sync_head),
    .rdata (sync_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b1;
      done        <= 1'b0;
      push_ok     <= 1'b0;
      pop_valid   <= 1'b0;
      pop_is_sync <= 1'b0;
      post_rd     <= '0;
      post_wr     <= '0;
      sync_head   <= '0;
      sync_tail   <= '0;
      sync_count  <= '0;
    end else begin
      busy        <= 1'b0;
      done        <= accept;
      push_ok     <= post_push || sync_push;
      pop_valid   <= sync_pop || post_pop;
      pop_is_sync <= sync_pop;
      if (post_push) begin
        post_wr <= post_wr_inc;
      end
      if (post_pop) begin
        post_rd <= post_rd_inc;
      end
      if (sync_push) begin
        sync_tail  <= sync_tail_inc;
        sync_count <= sync_count + 1'b1;
      end
      if (sync_pop) begin
        sync_head  <= sync_head_inc;
        sync_count <= sync_count - 1'b1;
      end
    end
  end

  assign sel_evt     = pop_is_sync ? sync_rdata : post_rdata;
  assign out_handler = pop_valid ? sel_evt.handler : '0;
  assign out_event   = pop_valid ? sel_evt.evt     : '0;
  assign out_word    = pop_valid ? sel_evt.word    : '0;
  assign out_tag     = pop_valid ? sel_evt.tag     : '0;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sync_count <= dpeq_pkg::SYNC_CW'(dpeq_pkg::SYNC_DEPTH))
    else $error("sync count beyond depth");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("item taken without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result without item");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    !(push_ok && pop_valid) && (!pop_is_sync || pop_valid))
    else $error("inconsistent result flags");

  a_post_full_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && op == dpeq_pkg::OP_PUSH_POST && post_wr_inc == post_rd) |=> $stable(post_wr))
    else $error("push into full posted ring moved the write index");
`endif

endmodule
`default_nettype wire
